// File: sv/tcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and constants of the telnet command filter: command codes,
// parser modes, result kinds and the configuration register map.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] TN_IAC  = 8'd255;
    localparam logic [BYTE_W-1:0] TN_DONT = 8'd254;
    localparam logic [BYTE_W-1:0] TN_DO   = 8'd253;
    localparam logic [BYTE_W-1:0] TN_WONT = 8'd252;
    localparam logic [BYTE_W-1:0] TN_WILL = 8'd251;

    // Register index, taken from paddr[2] (one 32-bit register per word).
    localparam logic REG_FORWARD_DATA = 1'b0;
    localparam logic FORWARD_RESET    = 1'b1;

    typedef enum logic [2:0] {
        MODE_DATA     = 3'd0,
        MODE_IAC      = 3'd1,
        MODE_OPT_DO   = 3'd2,
        MODE_OPT_DONT = 3'd3,
        MODE_OPT_WILL = 3'd4,
        MODE_OPT_WONT = 3'd5
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_WONT = 2'd1,
        KIND_DONT = 2'd2
    } t_kind;

    typedef struct packed {
        logic              emit;
        t_kind             kind;
        logic [BYTE_W-1:0] value;
    } t_result;

endpackage
`default_nettype wire

// File: sv/tcf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_if
// Valid/ready channels of the telnet command filter: received bytes in,
// data bytes and refusal requests out.
// ----------------------------------------------------------------------------
interface tcf_rx_if;
    logic                       valid;
    logic                       ready;
    logic [tcf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcf_res_if;
    logic                       valid;
    logic                       ready;
    logic [tcf_pkg::KIND_W-1:0] out_kind;
    logic [tcf_pkg::BYTE_W-1:0] out_value;

    modport source (output valid, output out_kind, output out_value, input ready);
    modport sink   (input valid, input out_kind, input out_value, output ready);
endinterface
`default_nettype wire

// File: sv/telnet_command_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_command_filter
// Receive-side telnet filter: strips IAC command sequences, passes data bytes
// on if forward_data is set and asks for IAC WONT / IAC DONT replies to DO / WILL.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  i_rx     in   valid / ready    rx_byte[7:0]
//  o_res    out  valid / ready    out_kind[1:0], out_value[7:0]
//  APB      in   psel / penable   paddr[2:0], pwdata[31:0] (forward_data)
//
//  One item per cycle sustained while o_res is not stalled. An accepted byte
//  passes the input register, then the result register, before its result is
//  on o_res. The parse mode is the only loop and updates once per byte.
//  When the result register is stalled, one more byte is held in the input
//  register before i_rx.ready drops.
//  Reset is synchronous: parse mode to normal data, forwarding enabled.
// ----------------------------------------------------------------------------
module telnet_command_filter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tcf_rx_if.sink                           i_rx,
    tcf_res_if.source                        o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tcf_pkg::PDATA_W-1:0] pwdata,
    output logic      [tcf_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    logic                       r_in_valid;
    logic [tcf_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    logic [tcf_pkg::KIND_W-1:0] r_out_kind;
    logic [tcf_pkg::BYTE_W-1:0] r_out_value;
    logic                       r_fwd;

    logic             w_out_free;
    logic             w_step;
    tcf_pkg::t_result w_res;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_step     = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_step;

    tcf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_fwd   (r_fwd),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res.emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.emit) begin
            r_out_kind  <= tcf_pkg::KIND_W'(w_res.kind);
            r_out_value <= w_res.value;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_kind  = r_out_kind;
    assign o_res.out_value = r_out_value;

    // Register file: only forward_data; other words read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= tcf_pkg::FORWARD_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == tcf_pkg::REG_FORWARD_DATA)) begin
            r_fwd <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tcf_pkg::REG_FORWARD_DATA) begin
            prdata[0] = r_fwd;
        end
    end

    assign pready = 1'b1;

endmodule
`default_nettype wire

// File: sv/tcf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_parser
// Telnet command parser: holds the parse mode and decides, for one byte,
// whether a data byte or an option refusal is emitted.
// ----------------------------------------------------------------------------
module tcf_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [tcf_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_fwd,
    output tcf_pkg::t_result                o_res
);

    tcf_pkg::t_mode r_mode;
    tcf_pkg::t_mode n_mode;

    always_comb begin
        n_mode = tcf_pkg::MODE_DATA;
        case (r_mode)
            tcf_pkg::MODE_IAC: begin
                if (i_byte == tcf_pkg::TN_DO) begin
                    n_mode = tcf_pkg::MODE_OPT_DO;
                end else if (i_byte == tcf_pkg::TN_DONT) begin
                    n_mode = tcf_pkg::MODE_OPT_DONT;
                end else if (i_byte == tcf_pkg::TN_WILL) begin
                    n_mode = tcf_pkg::MODE_OPT_WILL;
                end else if (i_byte == tcf_pkg::TN_WONT) begin
                    n_mode = tcf_pkg::MODE_OPT_WONT;
                end
            end
            tcf_pkg::MODE_OPT_DO,
            tcf_pkg::MODE_OPT_DONT,
            tcf_pkg::MODE_OPT_WILL,
            tcf_pkg::MODE_OPT_WONT: begin
                n_mode = tcf_pkg::MODE_DATA;
            end
            default: begin
                if (i_byte == tcf_pkg::TN_IAC) begin
                    n_mode = tcf_pkg::MODE_IAC;
                end
            end
        endcase
    end

    always_comb begin
        o_res.emit  = 1'b0;
        o_res.kind  = tcf_pkg::KIND_DATA;
        o_res.value = i_byte;
        case (r_mode)
            tcf_pkg::MODE_IAC: begin
                // A doubled IAC is one literal data byte of 255.
                o_res.emit = (i_byte == tcf_pkg::TN_IAC) && i_fwd;
            end
            tcf_pkg::MODE_OPT_DO: begin
                o_res.emit = 1'b1;
                o_res.kind = tcf_pkg::KIND_WONT;
            end
            tcf_pkg::MODE_OPT_WILL: begin
                o_res.emit = 1'b1;
                o_res.kind = tcf_pkg::KIND_DONT;
            end
            tcf_pkg::MODE_OPT_DONT,
            tcf_pkg::MODE_OPT_WONT: begin
                o_res.emit = 1'b0;
            end
            default: begin
                o_res.emit = (i_byte != tcf_pkg::TN_IAC) && i_fwd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tcf_pkg::MODE_DATA;
        end else if (i_step) begin
            r_mode <= n_mode;
        end
    end

endmodule
`default_nettype wire

// File: sv/tcf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_checker
// Port-level checks of the telnet command filter, bound to the top level.
// ----------------------------------------------------------------------------
module tcf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_rx_valid,
    input wire logic                       i_rx_ready,
    input wire logic                       i_res_valid,
    input wire logic                       i_res_ready,
    input wire logic [tcf_pkg::KIND_W-1:0] i_res_kind,
    input wire logic [tcf_pkg::BYTE_W-1:0] i_res_value
);

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_kind) && $stable(i_res_value))
        else $error("stalled result changed");

    // Input back-pressure only arises from a stalled, full result register.
    a_rx_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx_ready |-> i_res_valid && !i_res_ready)
        else $error("input stalled without a stalled result");

    // A fresh result is the outcome of an earlier item taken on i_rx.
    a_res_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("result appeared without a matching item");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_kind == tcf_pkg::KIND_DATA)
            || (i_res_kind == tcf_pkg::KIND_WONT)
            || (i_res_kind == tcf_pkg::KIND_DONT))
        else $error("undefined result kind");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.out_kind),
    .i_res_value (o_res.out_value)
);
`default_nettype wire
